// ===== rtl/core/hdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram distance tracker package
// Shared types, field widths and operation codes of the tracker.
// ----------------------------------------------------------------------------
package hdt_pkg;

   localparam int DEGREE_BINS_DEFAULT = 1024;
   localparam int COUNT_BITS_DEFAULT  = 20;

   localparam int FUNC_BITS      = 2;
   localparam int IDX_BITS       = 10;
   localparam int CNT_FIELD_BITS = 20;
   localparam int ADDR_FIELD_BITS = IDX_BITS + 1;
   localparam int ERR_BITS       = 2;
   localparam int OP_BITS        = 2;

   localparam int SUM_BITS       = 64;
   localparam int SHOWN_BITS     = 50;
   localparam int ROOT_BITS      = 33;
   localparam int ROOT_STEPS     = 33;
   localparam int ROOT_X_BITS    = 2 * ROOT_STEPS;
   localparam int ROOT_REM_BITS  = ROOT_BITS + 2;
   localparam int ROOT_FRAC_PAD  = ROOT_X_BITS - SHOWN_BITS;
   localparam int STEP_BITS      = $clog2(ROOT_STEPS);

   localparam int QUEUE_DEPTH    = 2;

   localparam logic [FUNC_BITS-1:0] FUNC_WRITE_TARGET  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_WRITE_CURRENT = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_MOVE          = 2'd2;

   localparam logic [ERR_BITS-1:0] ERR_OK        = 2'd0;
   localparam logic [ERR_BITS-1:0] ERR_RANGE     = 2'd1;
   localparam logic [ERR_BITS-1:0] ERR_UNDERFLOW = 2'd2;

   localparam logic [OP_BITS-1:0] OP_NOP           = 2'd0;
   localparam logic [OP_BITS-1:0] OP_WRITE_TARGET  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_WRITE_CURRENT = 2'd2;
   localparam logic [OP_BITS-1:0] OP_MOVE          = 2'd3;

   typedef struct packed {
      logic [FUNC_BITS-1:0]      func;
      logic [IDX_BITS-1:0]       bin_index;
      logic [CNT_FIELD_BITS-1:0] bin_count;
      logic [IDX_BITS-1:0]       new_degree;
      logic                      direction;
   } req_type;

   typedef struct packed {
      logic [SHOWN_BITS-1:0] distance_squared;
      logic [ROOT_BITS-1:0]  distance_root;
      logic [ERR_BITS-1:0]   error_code;
   } rsp_type;

   typedef struct packed {
      logic [OP_BITS-1:0]         op;
      logic [ADDR_FIELD_BITS-1:0] first_addr;
      logic [ADDR_FIELD_BITS-1:0] second_addr;
      logic [CNT_FIELD_BITS-1:0]  value;
      logic [ERR_BITS-1:0]        err;
   } op_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

// ===== rtl/core/hdt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hdt_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hdt_front.sv =====
// ----------------------------------------------------------------------------
// Histogram distance tracker front end
// Accepts request transactions, checks bin ranges, works out the old degree
// bin of a move and hands a decoded operation to the queue.
// ----------------------------------------------------------------------------
module hdt_front #(
   parameter int DEGREE_BINS = hdt_pkg::DEGREE_BINS_DEFAULT,
   parameter int COUNT_BITS  = hdt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hdt_pkg::req_type         req_data,
   input  hdt_pkg::queue_status_type queue_status,
   input  hdt_pkg::back_status_type back_status,
   output logic                     push,
   output hdt_pkg::op_entry_type    push_entry
);

   import hdt_pkg::*;

   localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
   localparam logic [31:0] BINS = 32'(DEGREE_BINS);

   logic [CNT_FIELD_BITS-1:0]  sat_count;
   logic [ADDR_FIELD_BITS-1:0] old_degree;
   logic                       move_ok;

   assign req_stall = queue_status.full || back_status.clearing;
   assign push      = req_valid && !req_stall;

   always_comb begin
      sat_count = (64'(req_data.bin_count) > COUNT_MAX) ?
                  CNT_FIELD_BITS'(COUNT_MAX) : req_data.bin_count;
      if (req_data.direction) begin
         old_degree = {1'b0, req_data.new_degree} - ADDR_FIELD_BITS'(1);
         move_ok    = (32'(req_data.new_degree) < BINS) && (req_data.new_degree != '0);
      end else begin
         old_degree = {1'b0, req_data.new_degree} + ADDR_FIELD_BITS'(1);
         move_ok    = (32'(req_data.new_degree) < BINS) && (32'(old_degree) < BINS);
      end

      push_entry             = '0;
      push_entry.op          = OP_NOP;
      push_entry.err         = ERR_OK;
      push_entry.value       = sat_count;
      push_entry.first_addr  = {1'b0, req_data.bin_index};
      push_entry.second_addr = {1'b0, req_data.new_degree};

      unique case (req_data.func)
         FUNC_WRITE_TARGET, FUNC_WRITE_CURRENT: begin
            if (32'(req_data.bin_index) < BINS) begin
               push_entry.op = (req_data.func == FUNC_WRITE_TARGET) ?
                               OP_WRITE_TARGET : OP_WRITE_CURRENT;
            end else begin
               push_entry.err = ERR_RANGE;
            end
         end
         FUNC_MOVE: begin
            if (move_ok) begin
               push_entry.op         = OP_MOVE;
               push_entry.first_addr = old_degree;
            end else begin
               push_entry.err = ERR_RANGE;
            end
         end
         default: begin
            push_entry.op = OP_NOP;
         end
      endcase
   end

endmodule

// ===== rtl/core/hdt_queue.sv =====
// ----------------------------------------------------------------------------
// Histogram distance tracker operation queue
// A short FIFO of decoded operations between the front end and the back end.
// ----------------------------------------------------------------------------
module hdt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  hdt_pkg::op_entry_type     push_entry,
   input  logic                      pop,
   output hdt_pkg::op_entry_type     head_entry,
   output hdt_pkg::queue_status_type status
);

   import hdt_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);

   op_entry_type        entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/hdt_back.sv =====
// ----------------------------------------------------------------------------
// Histogram distance tracker back end
// Clears both histograms after reset, performs the bin read-modify-write
// updates of the running sum of squares, takes the square root digit by
// digit and holds the result in an output register.
// ----------------------------------------------------------------------------
module hdt_back #(
   parameter int DEGREE_BINS = hdt_pkg::DEGREE_BINS_DEFAULT,
   parameter int COUNT_BITS  = hdt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hdt_pkg::op_entry_type     head_entry,
   input  hdt_pkg::queue_status_type queue_status,
   output logic                      pop,
   output hdt_pkg::back_status_type  status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output hdt_pkg::rsp_type          rsp_data
);

   import hdt_pkg::*;

   localparam int ADDR_W  = $clog2(DEGREE_BINS);
   localparam int SQ_BITS = 2 * COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEGREE_BINS - 1);
   localparam logic [SUM_BITS-1:0] SHOWN_MAX =
      {{(SUM_BITS - SHOWN_BITS){1'b0}}, {SHOWN_BITS{1'b1}}};
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(ROOT_STEPS - 1);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_READ  = 4'd2;
   localparam logic [3:0] ST_DIFF  = 4'd3;
   localparam logic [3:0] ST_MULT  = 4'd4;
   localparam logic [3:0] ST_ACCUM = 4'd5;
   localparam logic [3:0] ST_LOAD  = 4'd6;
   localparam logic [3:0] ST_ROOT  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0]               state_ff, state_in;
   logic [ADDR_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;

   op_entry_type             item_ff, item_in;
   logic                     phase_ff, phase_in;
   logic [ERR_BITS-1:0]      err_ff, err_in;
   logic [COUNT_BITS-1:0]    d_old_ff, d_old_in;
   logic [COUNT_BITS-1:0]    d_new_ff, d_new_in;
   logic [SQ_BITS-1:0]       sq_old_ff, sq_new_ff;
   logic [SHOWN_BITS-1:0]    shown_ff, shown_in;
   logic [ROOT_X_BITS-1:0]   x_ff, x_in;
   logic [ROOT_REM_BITS-1:0] rem_ff, rem_in;
   logic [ROOT_BITS-1:0]     root_ff, root_in;
   rsp_type                  rsp_data_ff;
   logic                     rsp_load;

   logic [ADDR_W-1:0]        cur_addr;
   logic                     rd_en;
   logic                     cur_wr_en, tgt_wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [COUNT_BITS-1:0]    wr_data;
   logic [COUNT_BITS-1:0]    cur_rd, tgt_rd;
   logic                     is_cur, do_dec, do_inc, wr_ok;
   logic [COUNT_BITS-1:0]    new_val, c_new, t_new;
   logic [SUM_BITS-1:0]      sum_next;
   logic [SHOWN_BITS-1:0]    shown_now;
   logic [ROOT_REM_BITS+1:0] rem_sh, trial;
   logic                     root_ge;

   hdt_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEGREE_BINS)) u_current_ram (
      .clock   (clock),
      .wr_en   (cur_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cur_addr),
      .rd_data (cur_rd)
   );

   hdt_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEGREE_BINS)) u_target_ram (
      .clock   (clock),
      .wr_en   (tgt_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cur_addr),
      .rd_data (tgt_rd)
   );

   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   assign cur_addr = phase_ff ? ADDR_W'(item_ff.second_addr) : ADDR_W'(item_ff.first_addr);
   assign is_cur   = (item_ff.op != OP_WRITE_TARGET);
   assign do_dec   = (item_ff.op == OP_MOVE) && !phase_ff;
   assign do_inc   = (item_ff.op == OP_MOVE) && phase_ff;

   always_comb begin
      wr_ok   = 1'b1;
      new_val = COUNT_BITS'(item_ff.value);
      if (do_dec) begin
         if (cur_rd == '0) begin
            wr_ok   = 1'b0;
            new_val = cur_rd;
         end else begin
            new_val = cur_rd - COUNT_BITS'(1);
         end
      end else if (do_inc) begin
         if (cur_rd == COUNT_MAX) begin
            wr_ok   = 1'b0;
            new_val = cur_rd;
         end else begin
            new_val = cur_rd + COUNT_BITS'(1);
         end
      end
      c_new = is_cur ? new_val : cur_rd;
      t_new = is_cur ? tgt_rd : new_val;
   end

   assign sum_next  = sum_ff - SUM_BITS'(sq_old_ff) + SUM_BITS'(sq_new_ff);
   assign shown_now = (sum_ff > SHOWN_MAX) ? SHOWN_MAX[SHOWN_BITS-1:0] : sum_ff[SHOWN_BITS-1:0];
   assign rem_sh    = {rem_ff, x_ff[ROOT_X_BITS-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign root_ge   = (rem_sh >= trial);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      sum_in       = sum_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_load     = 1'b0;
      item_in      = item_ff;
      phase_in     = phase_ff;
      err_in       = err_ff;
      d_old_in     = d_old_ff;
      d_new_in     = d_new_ff;
      shown_in     = shown_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      cur_wr_en    = 1'b0;
      tgt_wr_en    = 1'b0;
      wr_addr      = cur_addr;
      wr_data      = new_val;

      unique case (state_ff)
         ST_CLEAR: begin
            cur_wr_en = 1'b1;
            tgt_wr_en = 1'b1;
            wr_addr   = clr_addr_ff;
            wr_data   = '0;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!queue_status.empty) begin
               pop      = 1'b1;
               item_in  = head_entry;
               err_in   = head_entry.err;
               phase_in = 1'b0;
               state_in = (head_entry.op == OP_NOP) ? ST_LOAD : ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cur_wr_en = is_cur && wr_ok;
            tgt_wr_en = !is_cur && wr_ok;
            if (do_dec && !wr_ok) begin
               err_in = ERR_UNDERFLOW;
            end
            d_old_in = (cur_rd >= tgt_rd) ? cur_rd - tgt_rd : tgt_rd - cur_rd;
            d_new_in = (c_new >= t_new) ? c_new - t_new : t_new - c_new;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in = sum_next;
            if (do_dec) begin
               phase_in = 1'b1;
               state_in = ST_READ;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            shown_in = shown_now;
            x_in     = {shown_now, {ROOT_FRAC_PAD{1'b0}}};
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = root_ge ? ROOT_REM_BITS'(rem_sh - trial) : ROOT_REM_BITS'(rem_sh);
            root_in = {root_ff[ROOT_BITS-2:0], root_ge};
            x_in    = x_ff << 2;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         sum_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         sum_ff       <= sum_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      phase_ff  <= phase_in;
      err_ff    <= err_in;
      d_old_ff  <= d_old_in;
      d_new_ff  <= d_new_in;
      sq_old_ff <= SQ_BITS'(d_old_ff) * SQ_BITS'(d_old_ff);
      sq_new_ff <= SQ_BITS'(d_new_ff) * SQ_BITS'(d_new_ff);
      shown_ff  <= shown_in;
      x_ff      <= x_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      if (rsp_load) begin
         rsp_data_ff.distance_squared <= shown_ff;
         rsp_data_ff.distance_root    <= root_ff;
         rsp_data_ff.error_code       <= err_ff;
      end
   end

endmodule

// ===== rtl/core/histogram_distance_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Histogram distance tracker unit
// Keeps a target and a current degree histogram and the exact sum of squared
// bin differences, and reports that sum with its square root per transaction.
// ----------------------------------------------------------------------------
// After reset the unit clears both histograms, one bin per cycle, and holds
// req_stall high until the last bin is cleared. Each request transaction
// then gives exactly one response transaction, in order. The back end works
// on one operation at a time: a bin write does one read-modify-write of the
// two histogram memories, a degree move two and a rejected or unused request
// none, and each then passes through the 33-step square root unit. A
// two-entry queue lets the front end take requests while the back end is busy,
// and a response register lets the back end finish while the result waits.
module histogram_distance_tracker_unit #(
   parameter int DEGREE_BINS = hdt_pkg::DEGREE_BINS_DEFAULT,
   parameter int COUNT_BITS  = hdt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hdt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hdt_pkg::rsp_type rsp_data
);

   import hdt_pkg::*;

   queue_status_type queue_status;
   back_status_type  back_status;
   logic             push;
   op_entry_type     push_entry;
   logic             pop;
   op_entry_type     head_entry;

   hdt_front #(.DEGREE_BINS(DEGREE_BINS), .COUNT_BITS(COUNT_BITS)) u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .queue_status (queue_status),
      .back_status  (back_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   hdt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   hdt_back #(.DEGREE_BINS(DEGREE_BINS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .status       (back_status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== rtl/core/hdt_checker.sv =====
// ----------------------------------------------------------------------------
// Histogram distance tracker port checker
// Watches the ports of the tracker unit and flags behavior that breaks its
// contract.
// ----------------------------------------------------------------------------
module hdt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input hdt_pkg::rsp_type rsp_data
);

   import hdt_pkg::*;

   // The clearing pass starts right after reset, so no transaction is taken.
   assert property (@(posedge clock) reset |=> !rsp_valid && req_stall)
      else $error("Unit not idle and stalled after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response transaction changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.error_code == ERR_OK) ||
                    (rsp_data.error_code == ERR_RANGE) ||
                    (rsp_data.error_code == ERR_UNDERFLOW))
      else $error("Response carries an unknown error code.");

   // The root is the floor of the square root of the sum scaled by 65536.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (68'(rsp_data.distance_root) * 68'(rsp_data.distance_root)
            <= 68'({rsp_data.distance_squared, 16'h0000})) &&
         ((68'(rsp_data.distance_root) + 68'd1) * (68'(rsp_data.distance_root) + 68'd1)
            > 68'({rsp_data.distance_squared, 16'h0000})))
      else $error("Response root does not match the squared distance.");

endmodule

bind histogram_distance_tracker_unit hdt_checker u_hdt_checker (.*);

// ===== test/histogram_distance_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Histogram distance tracker unit testbench
// Drives target writes, current writes, degree moves and unused requests
// through the request channel with bursty timing while the response channel
// stalls on a rotating pattern. A mirror of both histograms and of the sum of
// squared differences predicts every response, which is compared field by
// field in order.
// ----------------------------------------------------------------------------
module histogram_distance_tracker_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import hdt_pkg::*;

   localparam int                        BINS        = DEGREE_BINS_DEFAULT;
   localparam logic [CNT_FIELD_BITS-1:0] COUNT_TOP   = '1;
   localparam logic [63:0]               SHOWN_TOP   = 64'h0003_FFFF_FFFF_FFFF;
   localparam logic [FUNC_BITS-1:0]      FUNC_UNUSED = 2'd3;

   class histogram_mirror;
      logic [CNT_FIELD_BITS-1:0] target_bins [BINS];
      logic [CNT_FIELD_BITS-1:0] current_bins [BINS];
      logic [63:0]               diff_sum;
      rsp_type                   expected_q [$];
      int unsigned               failures;

      function new();
         for (int i = 0; i < BINS; i++) begin
            target_bins[i] = '0;
            current_bins[i] = '0;
         end
         diff_sum = '0;
         failures = 0;
      endfunction

      function logic [63:0] bin_square(int unsigned i);
         logic [63:0] c;
         logic [63:0] t;
         logic [63:0] m;
         c = 64'(current_bins[i]);
         t = 64'(target_bins[i]);
         m = (c >= t) ? c - t : t - c;
         return m * m;
      endfunction

      function void store_bin(bit to_current, int unsigned i, logic [CNT_FIELD_BITS-1:0] value);
         diff_sum = diff_sum - bin_square(i);
         if (to_current) begin
            current_bins[i] = value;
         end else begin
            target_bins[i] = value;
         end
         diff_sum = diff_sum + bin_square(i);
      endfunction

      // Integer square root of the sum scaled by 2^16, one result bit at a time.
      function logic [ROOT_BITS-1:0] scaled_root(logic [SHOWN_BITS-1:0] s);
         logic [67:0] x;
         logic [67:0] trial;
         logic [67:0] root;
         int b;
         x = 68'(s) << 16;
         root = '0;
         for (b = ROOT_BITS - 1; b >= 0; b--) begin
            trial = root | (68'd1 << b);
            if (trial * trial <= x) begin
               root = trial;
            end
         end
         return root[ROOT_BITS-1:0];
      endfunction

      function void note_request(req_type r);
         int unsigned deg;
         int unsigned old_deg;
         bit ok;
         logic [ERR_BITS-1:0] err;
         logic [63:0] shown;
         rsp_type e;
         err = ERR_OK;
         deg = r.new_degree;
         case (r.func)
            FUNC_WRITE_TARGET, FUNC_WRITE_CURRENT: begin
               if (r.bin_index >= BINS) begin
                  err = ERR_RANGE;
               end else begin
                  store_bin(r.func == FUNC_WRITE_CURRENT, r.bin_index, r.bin_count);
               end
            end
            FUNC_MOVE: begin
               if (r.direction) begin
                  ok = deg < BINS && deg > 0;
                  old_deg = (deg > 0) ? deg - 1 : 0;
               end else begin
                  old_deg = deg + 1;
                  ok = deg < BINS && old_deg < BINS;
               end
               if (!ok) begin
                  err = ERR_RANGE;
               end else begin
                  if (current_bins[old_deg] == 0) begin
                     err = ERR_UNDERFLOW;
                  end else begin
                     store_bin(1'b1, old_deg, current_bins[old_deg] - 1'b1);
                  end
                  if (current_bins[deg] != COUNT_TOP) begin
                     store_bin(1'b1, deg, current_bins[deg] + 1'b1);
                  end
               end
            end
            default: begin
            end
         endcase
         shown = (diff_sum > SHOWN_TOP) ? SHOWN_TOP : diff_sum;
         e.distance_squared = shown[SHOWN_BITS-1:0];
         e.distance_root = scaled_root(shown[SHOWN_BITS-1:0]);
         e.error_code = err;
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_type r);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: response with none expected, actual %h", $time, r);
            failures++;
            return;
         end
         e = expected_q.pop_front();
         if (r.distance_squared !== e.distance_squared) begin
            $display("%0t: distance_squared expected %0d actual %0d",
                     $time, e.distance_squared, r.distance_squared);
            failures++;
         end
         if (r.distance_root !== e.distance_root) begin
            $display("%0t: distance_root expected %0d actual %0d",
                     $time, e.distance_root, r.distance_root);
            failures++;
         end
         if (r.error_code !== e.error_code) begin
            $display("%0t: error_code expected %0d actual %0d",
                     $time, e.error_code, r.error_code);
            failures++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   histogram_mirror mirror;

   histogram_distance_tracker_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("histogram_distance_tracker_unit regression: fail");
      $finish;
   end

   function automatic req_type make_request(logic [FUNC_BITS-1:0] func, int unsigned idx,
                                            logic [CNT_FIELD_BITS-1:0] cnt, int unsigned deg,
                                            bit dir);
      req_type r;
      r.func = func;
      r.bin_index = idx[IDX_BITS-1:0];
      r.bin_count = cnt;
      r.new_degree = deg[IDX_BITS-1:0];
      r.direction = dir;
      return r;
   endfunction

   // Most requests stay inside a 16-bin window so that moves find populated bins.
   function automatic req_type random_request(int unsigned base);
      req_type r;
      int unsigned pick;
      r = req_type'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         return r;
      end else if (pick < 25) begin
         r.func = FUNC_WRITE_TARGET;
         r.bin_index = IDX_BITS'(base + $urandom_range(0, 15));
         r.bin_count = ($urandom_range(0, 7) == 0) ? CNT_FIELD_BITS'($urandom)
                                                    : CNT_FIELD_BITS'($urandom_range(0, 6));
      end else if (pick < 45) begin
         r.func = FUNC_WRITE_CURRENT;
         r.bin_index = IDX_BITS'(base + $urandom_range(0, 15));
         r.bin_count = ($urandom_range(0, 7) == 0) ? CNT_FIELD_BITS'($urandom)
                                                    : CNT_FIELD_BITS'($urandom_range(0, 8));
      end else if (pick < 95) begin
         r.func = FUNC_MOVE;
         r.new_degree = IDX_BITS'(base + $urandom_range(0, 15));
      end else begin
         r.func = FUNC_UNUSED;
      end
      return r;
   endfunction

   task automatic send_request(req_type r);
      @(negedge clock);
      req_valid = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (!req_stall) begin
            break;
         end
      end
      mirror.note_request(r);
   endtask

   task automatic hold_off(int unsigned cycles);
      for (int k = 0; k < cycles; k++) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (mirror.pending() > 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         mirror.check_response(rsp_data);
      end
   end

   initial begin
      logic [12:0] stall_pattern;
      int unsigned cycle_count;
      stall_pattern = '0;
      cycle_count = 0;
      forever begin
         @(negedge clock);
         if (cycle_count % 97 == 0) begin
            if ($urandom_range(0, 3) == 0) begin
               stall_pattern = '0;
            end else begin
               stall_pattern = 13'($urandom) & 13'h0FFF;
            end
         end
         rsp_stall = stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[12:1]};
         cycle_count++;
      end
   end

   initial begin
      int unsigned base;
      int unsigned burst_left;
      mirror = new();
      repeat (6) @(negedge clock);
      reset = 1'b0;

      send_request(make_request(FUNC_WRITE_TARGET, 0, '0, 0, 1'b0));
      send_request(make_request(FUNC_WRITE_TARGET, BINS - 1, COUNT_TOP, BINS - 1, 1'b1));
      send_request(make_request(FUNC_WRITE_CURRENT, BINS - 1, COUNT_TOP, 0, 1'b0));
      send_request(make_request(FUNC_WRITE_CURRENT, 0, COUNT_TOP, 0, 1'b0));
      send_request(make_request(FUNC_WRITE_TARGET, 512, 20'h80000, 0, 1'b0));
      send_request(make_request(FUNC_WRITE_CURRENT, 3, 20'd2, 0, 1'b0));
      send_request(make_request(FUNC_MOVE, 0, '0, 4, 1'b1));
      send_request(make_request(FUNC_MOVE, 0, '0, 2, 1'b0));
      send_request(make_request(FUNC_MOVE, 0, '0, 0, 1'b1));
      send_request(make_request(FUNC_MOVE, 0, '0, BINS - 1, 1'b0));
      send_request(make_request(FUNC_MOVE, 0, '0, BINS - 1, 1'b1));
      send_request(make_request(FUNC_WRITE_CURRENT, 8, '0, 0, 1'b0));
      send_request(make_request(FUNC_WRITE_CURRENT, 7, COUNT_TOP, 0, 1'b0));
      send_request(make_request(FUNC_MOVE, 0, '0, 7, 1'b0));
      send_request(make_request(FUNC_MOVE, 0, '0, 0, 1'b0));
      send_request(make_request(FUNC_MOVE, 0, '0, 1, 1'b1));
      send_request(make_request(FUNC_UNUSED, BINS - 1, COUNT_TOP, BINS - 1, 1'b1));
      send_request(make_request(FUNC_WRITE_CURRENT, BINS - 1, '0, 0, 1'b0));
      send_request(make_request(FUNC_WRITE_TARGET, BINS - 1, '0, 0, 1'b0));
      wait_for_responses();

      base = 0;
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < 900; i++) begin
         if (i % 300 == 299) begin
            wait_for_responses();
         end
         if (i % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: base = 0;
               1: base = BINS - 16;
               default: base = $urandom_range(0, BINS - 16);
            endcase
         end
         send_request(random_request(base));
         burst_left--;
         if (burst_left == 0) begin
            hold_off($urandom_range(1, 60));
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
         end
      end

      wait_for_responses();
      repeat (100) @(posedge clock);
      if (mirror.failures == 0) begin
         $display("histogram_distance_tracker_unit regression: pass");
      end else begin
         $display("histogram_distance_tracker_unit regression: fail");
      end
      $finish;
   end

endmodule
